>>> src/srcb_pkg.sv
package srcb_pkg;

    // Shift chain lengths; the address and data fields themselves stay 16 and 8 bits wide.
    localparam int ADDRESS_BITS = 16;
    localparam int DATA_BITS    = 8;

    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 8;
    localparam int PINS_W  = 13;
    localparam int COUNT_W = 5;

    // Sequencer phases.
    localparam logic [3:0] PH_IDLE         = 4'd0;
    localparam logic [3:0] PH_RD_LOW       = 4'd1;
    localparam logic [3:0] PH_ADDR         = 4'd2;
    localparam logic [3:0] PH_ADDR_LATCH   = 4'd3;
    localparam logic [3:0] PH_CS_LOW       = 4'd4;
    localparam logic [3:0] PH_DIN_LATCH    = 4'd5;
    localparam logic [3:0] PH_DIN_LOAD     = 4'd6;
    localparam logic [3:0] PH_DIN_LOAD_END = 4'd7;
    localparam logic [3:0] PH_DIN          = 4'd8;
    localparam logic [3:0] PH_DOUT         = 4'd9;
    localparam logic [3:0] PH_DOUT_LATCH   = 4'd10;
    localparam logic [3:0] PH_STROBE_LOW   = 4'd11;
    localparam logic [3:0] PH_STROBE_HIGH  = 4'd12;
    localparam logic [3:0] PH_FINAL        = 4'd13;

    // Command kinds.
    localparam logic [1:0] FUNC_ROM_READ  = 2'd0;
    localparam logic [1:0] FUNC_RAM_READ  = 2'd1;
    localparam logic [1:0] FUNC_REG_WRITE = 2'd2;
    localparam logic [1:0] FUNC_RAM_WRITE = 2'd3;

    // Pin positions in the pin vector.
    localparam int PIN_ADDR_DATA  = 0;
    localparam int PIN_ADDR_SCLK  = 1;
    localparam int PIN_ADDR_LATCH = 2;
    localparam int PIN_DOUT_DATA  = 3;
    localparam int PIN_DOUT_SCLK  = 4;
    localparam int PIN_DOUT_LATCH = 5;
    localparam int PIN_OE_N       = 6;
    localparam int PIN_WR_N       = 7;
    localparam int PIN_RD_N       = 8;
    localparam int PIN_CS_N       = 9;
    localparam int PIN_DIN_LATCH  = 10;
    localparam int PIN_LOAD_N     = 11;
    localparam int PIN_DIN_SCLK   = 12;

    // All strobes and clocks high, both data pins low.
    localparam logic [PINS_W-1:0] PIN_RESET = 13'h1FF6;

    typedef struct packed {
        logic [3:0]         phase;
        logic [COUNT_W-1:0] bit_count;
        logic               half_step;
        logic [1:0]         command_kind;
        logic [ADDR_W-1:0]  address_hold;
        logic [DATA_W-1:0]  data_hold;
        logic [DATA_W-1:0]  gather_byte;
        logic [PINS_W-1:0]  pin_vector;
    } seq_state_t;

    typedef struct packed {
        logic              start_req;
        logic [1:0]        func;
        logic [ADDR_W-1:0] bus_address;
        logic [DATA_W-1:0] write_byte;
        logic              serial_in;
    } tick_item_t;

    typedef struct packed {
        logic [PINS_W-1:0] pins;
        logic              done_res;
        logic [DATA_W-1:0] read_byte;
        logic              busy_res;
    } tick_result_t;

endpackage

>>> src/srcb_step.sv
module srcb_step (
    input  srcb_pkg::seq_state_t   st_i,
    input  srcb_pkg::tick_item_t   item_i,
    output srcb_pkg::seq_state_t   st_o,
    output srcb_pkg::tick_result_t res_o
);

    srcb_pkg::seq_state_t st;
    srcb_pkg::seq_state_t nx;
    logic                 done;
    logic [4:0]           addr_idx;
    logic [4:0]           data_idx;
    logic                 addr_bit;
    logic                 data_bit;

    always_comb begin
        // Command start is folded into the same tick as its first pin update.
        st = st_i;
        if (st_i.phase == srcb_pkg::PH_IDLE && item_i.start_req) begin
            st.command_kind = item_i.func;
            st.address_hold = item_i.bus_address;
            st.data_hold    = item_i.write_byte;
            st.gather_byte  = '0;
            st.bit_count    = '0;
            st.half_step    = 1'b0;
            if (item_i.func == srcb_pkg::FUNC_ROM_READ || item_i.func == srcb_pkg::FUNC_RAM_READ) begin
                st.phase = srcb_pkg::PH_RD_LOW;
            end else begin
                st.phase = srcb_pkg::PH_ADDR;
            end
        end
    end

    // MSB-first bit selection; positions beyond the field width shift out as zero.
    assign addr_idx = 5'(srcb_pkg::ADDRESS_BITS - 1) - st.bit_count;
    assign data_idx = 5'(srcb_pkg::DATA_BITS - 1) - st.bit_count;
    assign addr_bit = (addr_idx < 5'(srcb_pkg::ADDR_W)) ? st.address_hold[addr_idx[3:0]] : 1'b0;
    assign data_bit = (data_idx < 5'(srcb_pkg::DATA_W)) ? st.data_hold[data_idx[2:0]] : 1'b0;

    always_comb begin
        nx   = st;
        done = 1'b0;
        case (st.phase)
            srcb_pkg::PH_IDLE: begin
                nx = st;
            end
            srcb_pkg::PH_RD_LOW: begin
                nx.pin_vector[srcb_pkg::PIN_RD_N] = 1'b0;
                nx.phase     = srcb_pkg::PH_ADDR;
                nx.bit_count = '0;
                nx.half_step = 1'b0;
            end
            srcb_pkg::PH_ADDR: begin
                if (!st.half_step) begin
                    nx.pin_vector[srcb_pkg::PIN_ADDR_LATCH] = 1'b0;
                    nx.pin_vector[srcb_pkg::PIN_ADDR_SCLK]  = 1'b0;
                    nx.pin_vector[srcb_pkg::PIN_ADDR_DATA]  = addr_bit;
                    nx.half_step = 1'b1;
                end else begin
                    nx.pin_vector[srcb_pkg::PIN_ADDR_SCLK] = 1'b1;
                    nx.half_step = 1'b0;
                    if (st.bit_count == 5'(srcb_pkg::ADDRESS_BITS - 1)) begin
                        nx.phase = srcb_pkg::PH_ADDR_LATCH;
                    end else begin
                        nx.bit_count = st.bit_count + 5'd1;
                    end
                end
            end
            srcb_pkg::PH_ADDR_LATCH: begin
                nx.pin_vector[srcb_pkg::PIN_ADDR_LATCH] = 1'b1;
                nx.bit_count = '0;
                nx.half_step = 1'b0;
                if (st.command_kind == srcb_pkg::FUNC_ROM_READ) begin
                    nx.phase = srcb_pkg::PH_DIN_LATCH;
                end else if (st.command_kind == srcb_pkg::FUNC_REG_WRITE) begin
                    nx.phase = srcb_pkg::PH_DOUT;
                end else begin
                    nx.phase = srcb_pkg::PH_CS_LOW;
                end
            end
            srcb_pkg::PH_CS_LOW: begin
                nx.pin_vector[srcb_pkg::PIN_CS_N] = 1'b0;
                nx.bit_count = '0;
                nx.half_step = 1'b0;
                if (st.command_kind == srcb_pkg::FUNC_RAM_READ) begin
                    nx.phase = srcb_pkg::PH_DIN_LATCH;
                end else begin
                    nx.phase = srcb_pkg::PH_DOUT;
                end
            end
            srcb_pkg::PH_DIN_LATCH: begin
                nx.pin_vector[srcb_pkg::PIN_DIN_LATCH] = 1'b0;
                nx.phase = srcb_pkg::PH_DIN_LOAD;
            end
            srcb_pkg::PH_DIN_LOAD: begin
                nx.pin_vector[srcb_pkg::PIN_DIN_LATCH] = 1'b1;
                nx.pin_vector[srcb_pkg::PIN_LOAD_N]    = 1'b0;
                nx.phase = srcb_pkg::PH_DIN_LOAD_END;
            end
            srcb_pkg::PH_DIN_LOAD_END: begin
                nx.pin_vector[srcb_pkg::PIN_LOAD_N] = 1'b1;
                nx.phase     = srcb_pkg::PH_DIN;
                nx.bit_count = '0;
                nx.half_step = 1'b0;
            end
            srcb_pkg::PH_DIN: begin
                if (!st.half_step) begin
                    nx.gather_byte = {st.gather_byte[srcb_pkg::DATA_W-2:0], item_i.serial_in};
                    nx.pin_vector[srcb_pkg::PIN_DIN_SCLK] = 1'b0;
                    nx.half_step = 1'b1;
                end else begin
                    nx.pin_vector[srcb_pkg::PIN_DIN_SCLK] = 1'b1;
                    nx.half_step = 1'b0;
                    if (st.bit_count == 5'(srcb_pkg::DATA_BITS - 1)) begin
                        nx.phase = srcb_pkg::PH_FINAL;
                    end else begin
                        nx.bit_count = st.bit_count + 5'd1;
                    end
                end
            end
            srcb_pkg::PH_DOUT: begin
                if (!st.half_step) begin
                    nx.pin_vector[srcb_pkg::PIN_DOUT_LATCH] = 1'b0;
                    nx.pin_vector[srcb_pkg::PIN_DOUT_SCLK]  = 1'b0;
                    nx.pin_vector[srcb_pkg::PIN_DOUT_DATA]  = data_bit;
                    nx.half_step = 1'b1;
                end else begin
                    nx.pin_vector[srcb_pkg::PIN_DOUT_SCLK] = 1'b1;
                    nx.half_step = 1'b0;
                    if (st.bit_count == 5'(srcb_pkg::DATA_BITS - 1)) begin
                        nx.phase = srcb_pkg::PH_DOUT_LATCH;
                    end else begin
                        nx.bit_count = st.bit_count + 5'd1;
                    end
                end
            end
            srcb_pkg::PH_DOUT_LATCH: begin
                nx.pin_vector[srcb_pkg::PIN_DOUT_LATCH] = 1'b1;
                nx.phase = srcb_pkg::PH_STROBE_LOW;
            end
            srcb_pkg::PH_STROBE_LOW: begin
                nx.pin_vector[srcb_pkg::PIN_OE_N] = 1'b0;
                nx.pin_vector[srcb_pkg::PIN_WR_N] = 1'b0;
                nx.phase = srcb_pkg::PH_STROBE_HIGH;
            end
            srcb_pkg::PH_STROBE_HIGH: begin
                nx.pin_vector[srcb_pkg::PIN_OE_N] = 1'b1;
                nx.pin_vector[srcb_pkg::PIN_WR_N] = 1'b1;
                if (st.command_kind == srcb_pkg::FUNC_RAM_WRITE) begin
                    nx.phase = srcb_pkg::PH_FINAL;
                end else begin
                    done     = 1'b1;
                    nx.phase = srcb_pkg::PH_IDLE;
                end
            end
            srcb_pkg::PH_FINAL: begin
                if (st.command_kind == srcb_pkg::FUNC_ROM_READ ||
                    st.command_kind == srcb_pkg::FUNC_RAM_READ) begin
                    nx.pin_vector[srcb_pkg::PIN_RD_N] = 1'b1;
                end
                if (st.command_kind == srcb_pkg::FUNC_RAM_READ ||
                    st.command_kind == srcb_pkg::FUNC_RAM_WRITE) begin
                    nx.pin_vector[srcb_pkg::PIN_CS_N] = 1'b1;
                end
                done     = 1'b1;
                nx.phase = srcb_pkg::PH_IDLE;
            end
            default: begin
                nx.phase = srcb_pkg::PH_IDLE;
            end
        endcase
    end

    always_comb begin
        st_o            = nx;
        res_o.pins      = nx.pin_vector;
        res_o.done_res  = done;
        res_o.busy_res  = (st.phase != srcb_pkg::PH_IDLE);
        res_o.read_byte = '0;
        if (done && (st.command_kind == srcb_pkg::FUNC_ROM_READ ||
                     st.command_kind == srcb_pkg::FUNC_RAM_READ)) begin
            res_o.read_byte = nx.gather_byte;
        end
    end

endmodule

>>> src/shift_register_cart_bus_sequencer_unit.sv
// Path: the accepting edge loads the input register; the result register is loaded
// when the tick advances, that is while it is empty or being drained by m_ready.
// Throughput: one input beat and one result beat per cycle while m_ready stays high;
// the combinational tick logic between the registers closes the sequencer state loop.
// Reset: aresetn is synchronous and active low; it empties both registers, returns
// the sequencer to idle and sets the held pin vector to all strobes and clocks high.
module shift_register_cart_bus_sequencer_unit (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_start_req,
    input  logic [1:0]                  s_func,
    input  logic [srcb_pkg::ADDR_W-1:0] s_bus_address,
    input  logic [srcb_pkg::DATA_W-1:0] s_write_byte,
    input  logic                        s_serial_in,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [srcb_pkg::PINS_W-1:0] m_pins,
    output logic                        m_done_res,
    output logic [srcb_pkg::DATA_W-1:0] m_read_byte,
    output logic                        m_busy_res
);

    // Input register: holds one tick until the result register can take its outcome.
    logic                  in_valid_reg;
    logic                  in_valid_next;
    srcb_pkg::tick_item_t  in_item_reg;

    // Sequencer state, advanced once per processed tick.
    srcb_pkg::seq_state_t  st_reg;
    srcb_pkg::seq_state_t  st_next;

    // Result register: parts the result channel from the input side.
    logic                  out_valid_reg;
    logic                  out_valid_next;
    srcb_pkg::tick_result_t out_reg;
    srcb_pkg::tick_result_t res_next;

    logic                  s_accept;
    logic                  advance;

    // A tick is processed whenever the result register is empty or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    assign in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    srcb_step u_step (
        .st_i   (st_reg),
        .item_i (in_item_reg),
        .st_o   (st_next),
        .res_o  (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '{phase: srcb_pkg::PH_IDLE, bit_count: '0, half_step: 1'b0,
                               command_kind: '0, address_hold: '0, data_hold: '0,
                               gather_byte: '0, pin_vector: srcb_pkg::PIN_RESET};
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                st_reg <= st_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.start_req   <= s_start_req;
            in_item_reg.func        <= s_func;
            in_item_reg.bus_address <= s_bus_address;
            in_item_reg.write_byte  <= s_write_byte;
            in_item_reg.serial_in   <= s_serial_in;
        end
        if (advance) begin
            out_reg <= res_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_pins      = out_reg.pins;
    assign m_done_res  = out_reg.done_res;
    assign m_read_byte = out_reg.read_byte;
    assign m_busy_res  = out_reg.busy_res;

endmodule

>>> dv/shift_register_cart_bus_sequencer_unit_test.sv
module shift_register_cart_bus_sequencer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import srcb_pkg::*;

    // The scoreboard carries its own copy of the sequencer state. Every
    // accepted input beat is one tick: it is run through the sequencer
    // model, and the pin vector, done flag, read byte and busy flag that
    // tick should produce are queued. Result beats come back in order and
    // are checked against the head of that queue.
    class pin_sequence_scoreboard;
        logic [3:0]         phase;
        logic [COUNT_W-1:0] bit_idx;
        logic               half;
        logic [1:0]         kind;
        logic [ADDR_W-1:0]  addr_q;
        logic [DATA_W-1:0]  data_q;
        logic [DATA_W-1:0]  gather;
        logic [PINS_W-1:0]  pins;
        tick_result_t       pending_ticks[$];
        int                 mismatches;

        function new();
            phase      = PH_IDLE;
            bit_idx    = '0;
            half       = 1'b0;
            kind       = FUNC_ROM_READ;
            addr_q     = '0;
            data_q     = '0;
            gather     = '0;
            pins       = PIN_RESET;
            mismatches = 0;
        endfunction

        function void note_tick(tick_item_t t);
            tick_result_t exp;
            logic         fin;
            int           shift;
            exp = '0;
            fin = 1'b0;
            if (phase == PH_IDLE && t.start_req) begin
                kind    = t.func;
                addr_q  = t.bus_address;
                data_q  = t.write_byte;
                gather  = '0;
                bit_idx = '0;
                half    = 1'b0;
                phase   = (t.func == FUNC_ROM_READ || t.func == FUNC_RAM_READ) ?
                          PH_RD_LOW : PH_ADDR;
            end
            if (phase != PH_IDLE) begin
                exp.busy_res = 1'b1;
                case (phase)
                    PH_RD_LOW: begin
                        pins[PIN_RD_N] = 1'b0;
                        phase   = PH_ADDR;
                        bit_idx = '0;
                        half    = 1'b0;
                    end
                    PH_ADDR: begin
                        if (!half) begin
                            shift = ADDRESS_BITS - 1 - int'(bit_idx);
                            pins[PIN_ADDR_LATCH] = 1'b0;
                            pins[PIN_ADDR_SCLK]  = 1'b0;
                            pins[PIN_ADDR_DATA]  = (shift < ADDR_W) ? addr_q[shift] : 1'b0;
                            half = 1'b1;
                        end else begin
                            pins[PIN_ADDR_SCLK] = 1'b1;
                            half = 1'b0;
                            if (int'(bit_idx) + 1 >= ADDRESS_BITS) phase = PH_ADDR_LATCH;
                            else bit_idx = bit_idx + 1'b1;
                        end
                    end
                    PH_ADDR_LATCH: begin
                        pins[PIN_ADDR_LATCH] = 1'b1;
                        bit_idx = '0;
                        half    = 1'b0;
                        if (kind == FUNC_ROM_READ) phase = PH_DIN_LATCH;
                        else if (kind == FUNC_REG_WRITE) phase = PH_DOUT;
                        else phase = PH_CS_LOW;
                    end
                    PH_CS_LOW: begin
                        pins[PIN_CS_N] = 1'b0;
                        bit_idx = '0;
                        half    = 1'b0;
                        phase   = (kind == FUNC_RAM_READ) ? PH_DIN_LATCH : PH_DOUT;
                    end
                    PH_DIN_LATCH: begin
                        pins[PIN_DIN_LATCH] = 1'b0;
                        phase = PH_DIN_LOAD;
                    end
                    PH_DIN_LOAD: begin
                        pins[PIN_DIN_LATCH] = 1'b1;
                        pins[PIN_LOAD_N]    = 1'b0;
                        phase = PH_DIN_LOAD_END;
                    end
                    PH_DIN_LOAD_END: begin
                        pins[PIN_LOAD_N] = 1'b1;
                        phase   = PH_DIN;
                        bit_idx = '0;
                        half    = 1'b0;
                    end
                    PH_DIN: begin
                        if (!half) begin
                            gather = {gather[DATA_W-2:0], t.serial_in};
                            pins[PIN_DIN_SCLK] = 1'b0;
                            half = 1'b1;
                        end else begin
                            pins[PIN_DIN_SCLK] = 1'b1;
                            half = 1'b0;
                            if (int'(bit_idx) + 1 >= DATA_BITS) phase = PH_FINAL;
                            else bit_idx = bit_idx + 1'b1;
                        end
                    end
                    PH_DOUT: begin
                        if (!half) begin
                            shift = DATA_BITS - 1 - int'(bit_idx);
                            pins[PIN_DOUT_LATCH] = 1'b0;
                            pins[PIN_DOUT_SCLK]  = 1'b0;
                            pins[PIN_DOUT_DATA]  = (shift < DATA_W) ? data_q[shift] : 1'b0;
                            half = 1'b1;
                        end else begin
                            pins[PIN_DOUT_SCLK] = 1'b1;
                            half = 1'b0;
                            if (int'(bit_idx) + 1 >= DATA_BITS) phase = PH_DOUT_LATCH;
                            else bit_idx = bit_idx + 1'b1;
                        end
                    end
                    PH_DOUT_LATCH: begin
                        pins[PIN_DOUT_LATCH] = 1'b1;
                        phase = PH_STROBE_LOW;
                    end
                    PH_STROBE_LOW: begin
                        pins[PIN_OE_N] = 1'b0;
                        pins[PIN_WR_N] = 1'b0;
                        phase = PH_STROBE_HIGH;
                    end
                    PH_STROBE_HIGH: begin
                        pins[PIN_OE_N] = 1'b1;
                        pins[PIN_WR_N] = 1'b1;
                        if (kind == FUNC_RAM_WRITE) begin
                            phase = PH_FINAL;
                        end else begin
                            fin   = 1'b1;
                            phase = PH_IDLE;
                        end
                    end
                    PH_FINAL: begin
                        if (kind == FUNC_ROM_READ || kind == FUNC_RAM_READ)
                            pins[PIN_RD_N] = 1'b1;
                        if (kind == FUNC_RAM_READ || kind == FUNC_RAM_WRITE)
                            pins[PIN_CS_N] = 1'b1;
                        fin   = 1'b1;
                        phase = PH_IDLE;
                    end
                    default: phase = PH_IDLE;
                endcase
                if (fin) begin
                    exp.done_res = 1'b1;
                    if (kind == FUNC_ROM_READ || kind == FUNC_RAM_READ)
                        exp.read_byte = gather;
                end
            end
            exp.pins = pins;
            pending_ticks.push_back(exp);
        endfunction

        function void check_result(tick_result_t r);
            tick_result_t exp;
            if (pending_ticks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: pins=%h done=%b byte=%h busy=%b",
                             r.pins, r.done_res, r.read_byte, r.busy_res);
                return;
            end
            exp = pending_ticks.pop_front();
            if (r.pins !== exp.pins || r.done_res !== exp.done_res ||
                r.read_byte !== exp.read_byte || r.busy_res !== exp.busy_res) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: pins %h/%h done %b/%b byte %h/%h busy %b/%b",
                             exp.pins, r.pins, exp.done_res, r.done_res,
                             exp.read_byte, r.read_byte, exp.busy_res, r.busy_res);
            end
        endfunction
    endclass

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic              s_start_req   = 1'b0;
    logic [1:0]        s_func        = FUNC_ROM_READ;
    logic [ADDR_W-1:0] s_bus_address = '0;
    logic [DATA_W-1:0] s_write_byte  = '0;
    logic              s_serial_in   = 1'b0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic [PINS_W-1:0] m_pins;
    logic              m_done_res;
    logic [DATA_W-1:0] m_read_byte;
    logic              m_busy_res;

    pin_sequence_scoreboard sb = new();

    // Percent of cycles in which the sender holds off a beat, and in which
    // the receiver drops ready.
    int send_idle_pct = 29;
    int recv_idle_pct = 80;
    int ticks_sent    = 0;

    shift_register_cart_bus_sequencer_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_start_req   (s_start_req),
        .s_func        (s_func),
        .s_bus_address (s_bus_address),
        .s_write_byte  (s_write_byte),
        .s_serial_in   (s_serial_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pins        (m_pins),
        .m_done_res    (m_done_res),
        .m_read_byte   (m_read_byte),
        .m_busy_res    (m_busy_res)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // The receiver decides afresh every cycle whether it can take a beat.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result beats are sampled at the clock edge that accepts them, so the
    // values seen are the ones that were stable through the cycle before.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result('{pins: m_pins, done_res: m_done_res,
                              read_byte: m_read_byte, busy_res: m_busy_res});
    end

    // Offers one tick as an input beat and returns at the edge that accepts
    // it. Valid is only lowered when the sender chooses to hold off, so a
    // beat that follows straight on keeps valid high without a glitch.
    task automatic send_tick(input tick_item_t t);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_start_req   <= t.start_req;
        s_func        <= t.func;
        s_bus_address <= t.bus_address;
        s_write_byte  <= t.write_byte;
        s_serial_in   <= t.serial_in;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_tick(t);
        ticks_sent++;
    endtask

    function automatic tick_item_t random_tick();
        tick_item_t t;
        t.start_req   = 1'($urandom_range(1));
        t.func        = 2'($urandom_range(3));
        t.bus_address = ADDR_W'($urandom_range(16'hFFFF));
        t.write_byte  = DATA_W'($urandom_range(8'hFF));
        t.serial_in   = 1'($urandom_range(1));
        return t;
    endfunction

    // Starts one command and keeps ticking until the sequencer is idle again.
    // The ticks inside the command carry random operands and often a fresh
    // start request, all of which the busy sequencer has to ignore. A
    // serial_fix of 0 or 1 pins the serial input; a negative one leaves it
    // random.
    task automatic run_command(input logic [1:0] kind, input logic [ADDR_W-1:0] addr,
                               input logic [DATA_W-1:0] data, input int serial_fix);
        tick_item_t t;
        t.start_req   = 1'b1;
        t.func        = kind;
        t.bus_address = addr;
        t.write_byte  = data;
        t.serial_in   = 1'($urandom_range(1));
        do begin
            if (serial_fix >= 0) t.serial_in = serial_fix[0];
            send_tick(t);
            t = random_tick();
        end while (sb.phase != PH_IDLE);
    endtask

    task automatic idle_tick();
        tick_item_t t;
        t = random_tick();
        t.start_req = 1'b0;
        send_tick(t);
    endtask

    // Random traffic: mostly complete commands back to back, with idle ticks
    // mixed in, until this phase has moved its share of beats.
    task automatic random_traffic(input int beats);
        int stop_at;
        stop_at = ticks_sent + beats;
        while (ticks_sent < stop_at) begin
            if ($urandom_range(99) < 80)
                run_command(2'($urandom_range(3)), ADDR_W'($urandom_range(16'hFFFF)),
                            DATA_W'($urandom_range(8'hFF)), -1);
            else
                idle_tick();
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Idle ticks right after reset must hold the reset pin pattern.
        send_tick('{start_req: 1'b0, func: FUNC_RAM_WRITE, bus_address: 16'hFFFF,
                    write_byte: 8'hFF, serial_in: 1'b1});
        send_tick('{start_req: 1'b0, func: FUNC_ROM_READ, bus_address: 16'h0000,
                    write_byte: 8'h00, serial_in: 1'b0});

        // Every command kind once; the reads use extreme operands and serial input
        // held high or low so that the read bytes come out all ones or zeros.
        run_command(FUNC_ROM_READ, 16'hFFFF, 8'h00, 1);
        run_command(FUNC_RAM_READ, 16'h0000, 8'hFF, 0);
        run_command(FUNC_REG_WRITE, 16'hA5A5, 8'hFF, -1);
        run_command(FUNC_RAM_WRITE, 16'h5A5A, 8'h00, -1);
        // A read right after a write shows that read_byte stays zero on the
        // final tick of the write and that data pins keep their last bit.
        run_command(FUNC_ROM_READ, 16'h8001, 8'h81, -1);
        idle_tick();

        random_traffic(60);
        send_idle_pct = 80;
        recv_idle_pct = 29;
        random_traffic(60);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(60);

        s_valid <= 1'b0;
        while (sb.pending_ticks.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (sb.mismatches == 0 && sb.pending_ticks.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // The whole run of beats fits well inside this timeout.
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> shift_register_cart_bus_sequencer_unit.f
src/srcb_pkg.sv
src/srcb_step.sv
src/shift_register_cart_bus_sequencer_unit.sv
dv/shift_register_cart_bus_sequencer_unit_test.sv
